[sv/pattern_step_sequencer_core_assert.svh]
// Assertion macros shared by the sequencer RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef PATTERN_STEP_SEQUENCER_CORE_ASSERT_SVH
`define PATTERN_STEP_SEQUENCER_CORE_ASSERT_SVH

// condition holds on every clock edge
`define PSS_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pss_pkg.sv]
// Shared types and constants for the pattern step sequencer.
// No dependencies.
package pss_pkg;

   localparam int STEP_COUNT_DEF  = 16;
   localparam int TRACK_COUNT_DEF = 8;
   localparam int MAX_EMIT        = 8;   // width of the track enable mask

   localparam int PHASE_W = 24;
   localparam int VEL_W   = 8;
   localparam int PITCH_W = 16;
   localparam int TRK_W   = 3;
   localparam int STEP_W  = 4;
   localparam int ENTRY_W = VEL_W + PITCH_W;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 24;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_PHASE_INC   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GATE_THRESH = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_TRACK_EN    = 2'd2;

   localparam logic [PHASE_W-1:0]  PHASE_INC_RST   = 24'd33554;
   localparam logic [PHASE_W-1:0]  GATE_THRESH_RST = 24'd10066330;
   localparam logic [MAX_EMIT-1:0] TRACK_EN_RST    = 8'hFF;
   localparam logic [VEL_W-1:0]    VEL_RST         = 8'd0;
   localparam logic [PITCH_W-1:0]  PITCH_RST       = 16'd768;   // 3.0 in Q8.8

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } st_type;

endpackage

[sv/pattern_step_sequencer_core.sv]
// Multi-track pattern step sequencer, top level.
// Request channel (req_*): kind 0 is a sample tick, kind 1 stores one pattern entry.
// Result channel (rsp_*): one word per enabled track for each tick, in ascending
// track order, with rsp_last set on the final word of the tick. Writes return nothing.
// Configuration (csr_*): write-only registers, index 0 phase increment, 1 gate
// threshold, 2 track enable; taken on any cycle with csr_we high.
// A tick's results pass the scan, the pattern memory read stage and the result register.
// The scan takes one step per track, min(TRACK_COUNT, 8) steps in all, with one pattern
// memory read per enabled track; the next word is taken in the scan's last cycle. A write
// is stored when accepted and leaves the block idle. Disabled tracks still take a scan step but produce nothing.
// Reset: the phase and step go to zero; a clearing pass fills all TRACK_COUNT*STEP_COUNT
// pattern memory entries (128 at the defaults); req_ready stays low until done.
// Stall: a read stage and the result register hold words while rsp_ready is low;
// the scan waits on the pattern memory read port and req_ready follows.
// Depends on pss_pkg, pss_phase and pss_seq.
module pattern_step_sequencer_core
   import pss_pkg::*;
#(
   parameter int STEP_COUNT  = STEP_COUNT_DEF,
   parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [TRK_W-1:0]    req_track_index,
   input  logic [STEP_W-1:0]   req_step_index,
   input  logic [VEL_W-1:0]    req_velocity_value,
   input  logic [PITCH_W-1:0]  req_pitch_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TRK_W-1:0]    rsp_track,
   output logic [STEP_W-1:0]   rsp_step,
   output logic [VEL_W-1:0]    rsp_gated_velocity,
   output logic [PITCH_W-1:0]  rsp_pitch,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   localparam int SW = $clog2(STEP_COUNT);

   logic [PHASE_W-1:0]  phase_inc_ff;
   logic [PHASE_W-1:0]  gate_thresh_ff;
   logic [MAX_EMIT-1:0] track_en_ff;

   logic          tick;
   logic [SW-1:0] cur_step;
   logic          gate_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff   <= PHASE_INC_RST;
         gate_thresh_ff <= GATE_THRESH_RST;
         track_en_ff    <= TRACK_EN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_INC:   phase_inc_ff   <= csr_wdata[PHASE_W-1:0];
            CSR_GATE_THRESH: gate_thresh_ff <= csr_wdata[PHASE_W-1:0];
            CSR_TRACK_EN:    track_en_ff    <= csr_wdata[MAX_EMIT-1:0];
            default: ;
         endcase
      end
   end

   pss_phase #(
      .STEP_COUNT (STEP_COUNT)
   ) u_phase (
      .clock           (clock),
      .reset           (reset),
      .tick            (tick),
      .phase_increment (phase_inc_ff),
      .gate_threshold  (gate_thresh_ff),
      .cur_step        (cur_step),
      .gate_open       (gate_open)
   );

   pss_seq #(
      .STEP_COUNT  (STEP_COUNT),
      .TRACK_COUNT (TRACK_COUNT)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_track_index    (req_track_index),
      .req_step_index     (req_step_index),
      .req_velocity_value (req_velocity_value),
      .req_pitch_value    (req_pitch_value),
      .track_enable       (track_en_ff),
      .cur_step           (cur_step),
      .gate_open          (gate_open),
      .tick               (tick),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_track          (rsp_track),
      .rsp_step           (rsp_step),
      .rsp_gated_velocity (rsp_gated_velocity),
      .rsp_pitch          (rsp_pitch),
      .rsp_last           (rsp_last)
   );

endmodule

[sv/pss_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
module pss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/pss_phase.sv]
// Step phase accumulator, step counter and gate compare.
// Depends on pss_pkg.
module pss_phase
   import pss_pkg::*;
#(
   parameter int STEP_COUNT = STEP_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic [PHASE_W-1:0]            phase_increment,
   input  logic [PHASE_W-1:0]            gate_threshold,
   output logic [$clog2(STEP_COUNT)-1:0] cur_step,
   output logic                          gate_open
);

   localparam int SW = $clog2(STEP_COUNT);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [PHASE_W:0]   phase_sum;

   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, phase_increment};
      phase_in  = phase_ff;
      step_in   = step_ff;
      if (tick) begin
         // carry out of the sum is the wrap past one step
         phase_in = phase_sum[PHASE_W-1:0];
         if (phase_sum[PHASE_W]) begin
            step_in = (step_ff == SW'(STEP_COUNT - 1)) ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   assign cur_step  = step_ff;
   assign gate_open = phase_ff < gate_threshold;

endmodule

[sv/pss_seq.sv]
// Track scan sequencer: pattern memory, clearing pass, read pipeline, result register.
// Depends on pss_pkg, pss_ram and the assertion macro header.
`include "pattern_step_sequencer_core_assert.svh"

module pss_seq
   import pss_pkg::*;
#(
   parameter int STEP_COUNT  = STEP_COUNT_DEF,
   parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [TRK_W-1:0]              req_track_index,
   input  logic [STEP_W-1:0]             req_step_index,
   input  logic [VEL_W-1:0]              req_velocity_value,
   input  logic [PITCH_W-1:0]            req_pitch_value,
   input  logic [MAX_EMIT-1:0]           track_enable,
   input  logic [$clog2(STEP_COUNT)-1:0] cur_step,
   input  logic                          gate_open,
   output logic                          tick,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [TRK_W-1:0]              rsp_track,
   output logic [STEP_W-1:0]             rsp_step,
   output logic [VEL_W-1:0]              rsp_gated_velocity,
   output logic [PITCH_W-1:0]            rsp_pitch,
   output logic                          rsp_last
);

   localparam int DEPTH = TRACK_COUNT * STEP_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(STEP_COUNT);
   localparam int NT    = (TRACK_COUNT < MAX_EMIT) ? TRACK_COUNT : MAX_EMIT;
   localparam int TW    = (NT > 1) ? $clog2(NT) : 1;

   st_type state_ff, state_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [TW-1:0] trk_ff, trk_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [TW-1:0] s1_track_ff;
   logic [SW-1:0] s1_step_ff;
   logic          s1_gate_ff;
   logic          s1_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TRK_W-1:0]   rsp_track_ff;
   logic [STEP_W-1:0]  rsp_step_ff;
   logic [VEL_W-1:0]   rsp_vel_ff;
   logic [PITCH_W-1:0] rsp_pitch_ff;
   logic               rsp_last_ff;

   logic trk_en, trk_final, more_after;
   logic out_free, s1_move, s1_free;
   logic trk_step, scan_done, accept, wr_ok;
   logic clr_done;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   // ---------------- handshake and pipeline flow ----------------
   always_comb begin
      more_after = 1'b0;
      for (int i = 0; i < NT; i++) begin
         if (i > int'(trk_ff) && track_enable[i]) begin
            more_after = 1'b1;
         end
      end
   end

   assign trk_en    = track_enable[trk_ff];
   assign trk_final = (trk_ff == TW'(NT - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign trk_step  = (state_ff == ST_SCAN) && (!trk_en || s1_free);
   assign scan_done = trk_step && trk_final;
   assign clr_done  = (clr_addr_ff == AW'(DEPTH - 1));

   // the next word may enter in the last scan cycle
   assign req_ready = (state_ff == ST_IDLE) || scan_done;
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_kind == KIND_TICK);
   assign wr_ok     = (32'(req_track_index) < TRACK_COUNT) &&
                      (32'(req_step_index) < STEP_COUNT);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (tick) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done && !tick) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      ram_we      = 1'b0;
      ram_waddr   = clr_addr_ff;
      ram_wdata   = {VEL_RST, PITCH_RST};
      ram_re      = 1'b0;
      ram_raddr   = AW'(32'(trk_ff) * STEP_COUNT + 32'(cur_step));
      clr_addr_in = clr_addr_ff;
      trk_in      = trk_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            trk_in = '0;
         end
         ST_SCAN: begin
            ram_re = trk_en && s1_free;
            if (trk_step) begin
               trk_in = trk_final ? '0 : trk_ff + 1'b1;
            end
         end
         default: begin
            trk_in = '0;
         end
      endcase
      // a write word stores its entry at the accept edge
      if (accept && req_kind == KIND_WRITE && wr_ok) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(32'(req_track_index) * STEP_COUNT + 32'(req_step_index));
         ram_wdata = {req_velocity_value, req_pitch_value};
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ram_re) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         trk_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         trk_ff       <= trk_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the read stage and the result register
   always_ff @(posedge clock) begin
      if (ram_re) begin
         s1_track_ff <= trk_ff;
         s1_step_ff  <= cur_step;
         s1_gate_ff  <= gate_open;
         s1_last_ff  <= !more_after;
      end
      if (s1_move) begin
         rsp_track_ff <= TRK_W'(s1_track_ff);
         rsp_step_ff  <= STEP_W'(s1_step_ff);
         rsp_vel_ff   <= s1_gate_ff ? ram_rdata[ENTRY_W-1:PITCH_W] : '0;
         rsp_pitch_ff <= ram_rdata[PITCH_W-1:0];
         rsp_last_ff  <= s1_last_ff;
      end
   end

   pss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_track          = rsp_track_ff;
   assign rsp_step           = rsp_step_ff;
   assign rsp_gated_velocity = rsp_vel_ff;
   assign rsp_pitch          = rsp_pitch_ff;
   assign rsp_last           = rsp_last_ff;

   // ---------------- assertions ----------------
   `PSS_ASSERT_IMP(a_no_s1_overwrite, ram_re, s1_free, "read issued over a held word")
   `PSS_ASSERT_NXT(a_s1_hold, s1_valid_ff && !s1_move,
                   s1_valid_ff && $stable(s1_track_ff), "stalled read stage lost its word")
   `PSS_ASSERT_IMP(a_clear_quiet, state_ff == ST_CLEAR, !ram_re && !req_ready,
                   "activity during clearing pass")
   `PSS_ASSERT(a_scan_no_write,
               !(ram_re && ram_we && ram_raddr == ram_waddr && !scan_done),
               "pattern write collides with scan read")

endmodule

[tb/sv/tb_pattern_step_sequencer_core.sv]
`timescale 1ns / 100ps
// Self-checking bench for pattern_step_sequencer_core: a scoreboard class predicts
// the per-track words of each tick and checks them in order. Needs pss_pkg and the RTL.
module tb_pattern_step_sequencer_core;
   import pss_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 16;    // covers read latency plus one full scan
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 25;
   localparam int PATTERN_DEPTH   = TRACK_COUNT_DEF * STEP_COUNT_DEF;

   typedef struct packed {
      logic                kind;
      logic [TRK_W-1:0]    track_index;
      logic [STEP_W-1:0]   step_index;
      logic [VEL_W-1:0]    velocity;
      logic [PITCH_W-1:0]  pitch;
   } seq_in_t;

   typedef struct packed {
      logic [TRK_W-1:0]    track;
      logic [STEP_W-1:0]   step;
      logic [VEL_W-1:0]    velocity;
      logic [PITCH_W-1:0]  pitch;
      logic                last;
   } seq_out_t;

   localparam seq_in_t TICK_WORD = '{KIND_TICK, 3'd0, 4'd0, 8'd0, 16'd0};

   class track_word_scoreboard;
      logic [PHASE_W-1:0]  phase_inc;
      logic [PHASE_W-1:0]  gate_thresh;
      logic [MAX_EMIT-1:0] track_en;
      logic [PHASE_W-1:0]  phase;
      logic [STEP_W-1:0]   cur_step;
      logic [VEL_W-1:0]    vel_mem [PATTERN_DEPTH];
      logic [PITCH_W-1:0]  pitch_mem [PATTERN_DEPTH];
      seq_out_t            expected_words[$];
      int                  failures;
      int                  words_seen;
      int                  ticks;
      int                  writes;

      function new();
         phase_inc   = PHASE_INC_RST;
         gate_thresh = GATE_THRESH_RST;
         track_en    = TRACK_EN_RST;
         phase       = '0;
         cur_step    = '0;
         for (int i = 0; i < PATTERN_DEPTH; i++) begin
            vel_mem[i]   = VEL_RST;
            pitch_mem[i] = PITCH_RST;
         end
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10)
            $display("MISMATCH: %s", msg);
      endfunction

      function void set_register(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx)
            CSR_PHASE_INC:   phase_inc   = data[PHASE_W-1:0];
            CSR_GATE_THRESH: gate_thresh = data[PHASE_W-1:0];
            CSR_TRACK_EN:    track_en    = data[MAX_EMIT-1:0];
            default: ;
         endcase
      endfunction

      // store a write's entry, or advance phase/step on a tick and queue one word per enabled track
      function void note_request(seq_in_t w);
         logic [PHASE_W:0] sum;
         logic             gate_open;
         int               addr;
         int               last_pos;
         seq_out_t         o;
         if (w.kind == KIND_WRITE) begin
            writes++;
            if (w.track_index < TRACK_COUNT_DEF && w.step_index < STEP_COUNT_DEF) begin
               addr = w.track_index * STEP_COUNT_DEF + w.step_index;
               vel_mem[addr]   = w.velocity;
               pitch_mem[addr] = w.pitch;
            end
            return;
         end
         ticks++;
         sum = {1'b0, phase} + {1'b0, phase_inc};
         if (sum[PHASE_W])
            cur_step = (cur_step == STEP_COUNT_DEF - 1) ? '0 : cur_step + 1'b1;
         phase     = sum[PHASE_W-1:0];
         gate_open = phase < gate_thresh;
         last_pos  = -1;
         for (int t = 0; t < TRACK_COUNT_DEF && t < MAX_EMIT; t++) begin
            if (track_en[t]) begin
               addr       = t * STEP_COUNT_DEF + cur_step;
               o.track    = t[TRK_W-1:0];
               o.step     = cur_step;
               o.velocity = gate_open ? vel_mem[addr] : '0;
               o.pitch    = pitch_mem[addr];
               o.last     = 1'b0;
               expected_words.push_back(o);
               last_pos = expected_words.size() - 1;
            end
         end
         if (last_pos >= 0)
            expected_words[last_pos].last = 1'b1;
      endfunction

      function void check_word(seq_out_t got);
         seq_out_t want;
         words_seen++;
         if (expected_words.size() == 0) begin
            flag($sformatf("unexpected word trk %0d step %0d vel %0d pitch %h last %0d",
                           got.track, got.step, got.velocity, got.pitch, got.last));
            return;
         end
         want = expected_words.pop_front();
         if (got.track !== want.track || got.step !== want.step ||
             got.velocity !== want.velocity || got.pitch !== want.pitch ||
             got.last !== want.last)
            flag($sformatf({"word %0d: expected trk %0d step %0d vel %0d pitch %h last %0d,",
                            " got trk %0d step %0d vel %0d pitch %h last %0d"},
                           words_seen, want.track, want.step, want.velocity, want.pitch,
                           want.last, got.track, got.step, got.velocity, got.pitch,
                           got.last));
      endfunction

      function void close();
         if (expected_words.size() != 0)
            flag($sformatf("%0d expected words never arrived", expected_words.size()));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_TICK;
   logic [TRK_W-1:0]    req_track_index = '0;
   logic [STEP_W-1:0]   req_step_index = '0;
   logic [VEL_W-1:0]    req_velocity_value = '0;
   logic [PITCH_W-1:0]  req_pitch_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TRK_W-1:0]    rsp_track;
   logic [STEP_W-1:0]   rsp_step;
   logic [VEL_W-1:0]    rsp_gated_velocity;
   logic [PITCH_W-1:0]  rsp_pitch;
   logic                rsp_last;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_index = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   track_word_scoreboard board;
   int cycle_count   = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int rx_count      = 0;
   int burst_left    = 0;
   int settings_used = 0;

   pattern_step_sequencer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_track_index    (req_track_index),
      .req_step_index     (req_step_index),
      .req_velocity_value (req_velocity_value),
      .req_pitch_value    (req_pitch_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_track          (rsp_track),
      .rsp_step           (rsp_step),
      .rsp_gated_velocity (rsp_gated_velocity),
      .rsp_pitch          (rsp_pitch),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: rotating stall patterns, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rx_count <= rx_count + 1;
         case ((rx_count / 64) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ((rx_count % 8) < 3);
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word('{rsp_track, rsp_step, rsp_gated_velocity, rsp_pitch, rsp_last});
   end

   // sender pacing: random bursts, now and then a long unbroken one
   task automatic pace_sender();
      int gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 8);
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(input seq_in_t w);
      req_valid          <= 1'b1;
      req_kind           <= w.kind;
      req_track_index    <= w.track_index;
      req_step_index     <= w.step_index;
      req_velocity_value <= w.velocity;
      req_pitch_value    <= w.pitch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(w);
      pace_sender();
   endtask

   // block goes idle: all words back, scan and write path drained
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [PHASE_W-1:0] inc, input logic [PHASE_W-1:0] gate,
                                 input logic [MAX_EMIT-1:0] en);
      csr_we    <= 1'b1;
      csr_index <= CSR_PHASE_INC;
      csr_wdata <= CSR_DW'(inc);
      @(posedge clock);
      csr_index <= CSR_GATE_THRESH;
      csr_wdata <= CSR_DW'(gate);
      @(posedge clock);
      csr_index <= CSR_TRACK_EN;
      csr_wdata <= CSR_DW'(en);
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_register(CSR_PHASE_INC, CSR_DW'(inc));
      board.set_register(CSR_GATE_THRESH, CSR_DW'(gate));
      board.set_register(CSR_TRACK_EN, CSR_DW'(en));
      settings_used++;
   endtask

   initial begin
      seq_in_t             w;
      logic [PHASE_W-1:0]  inc;
      logic [PHASE_W-1:0]  gate;
      logic [MAX_EMIT-1:0] en;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: cleared pattern first, then corner entries on steps 0, 1 and 15
      send_word(TICK_WORD);
      send_word('{KIND_WRITE, 3'd0, 4'd0, 8'hFF, 16'hFFFF});
      send_word('{KIND_WRITE, 3'd7, 4'd0, 8'hFF, 16'h0000});
      send_word('{KIND_WRITE, 3'd3, 4'd1, 8'h5A, 16'h1234});
      send_word('{KIND_WRITE, 3'd7, 4'd15, 8'hFF, 16'hFFFF});
      send_word('{KIND_WRITE, 3'd0, 4'd15, 8'h00, 16'h0000});
      send_word(TICK_WORD);
      settle();

      // max increment: wraps on every tick, gate nearly always open
      apply_settings(24'hFFFFFF, 24'hFFFFFF, 8'hFF);
      repeat (6) send_word(TICK_WORD);
      settle();

      // zero increment, gate closed, outer tracks only
      apply_settings(24'h000000, 24'h000000, 8'h81);
      repeat (3) send_word(TICK_WORD);
      settle();

      // nothing enabled: step still advances silently
      apply_settings(24'h800000, 24'h000001, 8'h00);
      repeat (3) send_word(TICK_WORD);
      send_word('{KIND_WRITE, 3'd7, 4'd1, 8'hA5, 16'h8001});
      settle();

      apply_settings(24'h800000, 24'h800000, 8'h80);
      repeat (4) send_word(TICK_WORD);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         inc  = ($urandom_range(0, 3) == 0) ? PHASE_W'($urandom) :
                PHASE_W'($urandom_range(24'h200000, 24'hFFFFFF));
         gate = PHASE_W'($urandom);
         case ($urandom_range(0, 7))
            0:       en = 8'h00;
            1, 2:    en = 8'hFF;
            3:       en = 8'h01 << $urandom_range(0, 7);
            default: en = MAX_EMIT'($urandom);
         endcase
         // the hold-off phase needs words in flight so the block backs up
         if (p == 1)
            en[0] = 1'b1;
         apply_settings(inc, gate, en);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            w.kind        = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_TICK;
            w.track_index = TRK_W'($urandom_range(0, 7));
            w.step_index  = STEP_W'($urandom_range(0, 15));
            w.velocity    = VEL_W'($urandom_range(0, 255));
            w.pitch       = PITCH_W'($urandom_range(0, 65535));
            if (p == 1 && n == 4)
               hold_requests <= hold_requests + 1;
            send_word(w);
         end
         settle();
      end

      board.close();
      $display("Run covered %0d ticks and %0d pattern writes over %0d register settings,",
               board.ticks, board.writes, settings_used + 1);
      $display("checking %0d result words with %0d failures.", board.words_seen,
               board.failures);
      if (board.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
